// ===== sv/btff_pkg.sv =====
package btff_pkg;

	// heap geometry
	localparam int HEAP_WORDS     = 4096;
	localparam int ADDR_W         = $clog2(HEAP_WORDS);
	localparam int EXT_W          = ADDR_W + 3;
	localparam int WORD_W         = ADDR_W + 2;
	localparam int STEP_W         = ADDR_W + 1;
	localparam int BYTES_W        = 15;
	localparam int BYTES_PER_WORD = 4;
	localparam int BPW_SHIFT      = $clog2(BYTES_PER_WORD);
	localparam int NEED_W         = BYTES_W - BPW_SHIFT + 2;

	// tag word layout: allocated, last, size
	localparam int LAST_POS  = ADDR_W;
	localparam int ALLOC_POS = ADDR_W + 1;

	localparam int MIN_BLOCK   = 3;
	localparam int SPLIT_SLACK = 3;

	// command modes
	localparam logic MODE_ALLOC = 1'b0;
	localparam logic MODE_FREE  = 1'b1;

	// result status codes
	localparam logic ST_DONE  = 1'b0;
	localparam logic ST_NOFIT = 1'b1;

	typedef struct packed {
		logic               mode;
		logic [BYTES_W-1:0] request_bytes;
		logic [ADDR_W-1:0]  block_offset;
	} cmd_t;

	typedef struct packed {
		logic              status;
		logic [ADDR_W-1:0] payload_offset;
	} res_t;

	typedef enum logic [4:0] {
		S_CLEAR,
		S_IDLE,
		S_A_CHK,
		S_A_TAG,
		S_A_ADV,
		S_A_NXT,
		S_A_WR,
		S_F_HDR,
		S_F_FTR,
		S_F_PRV,
		S_F_NXTCHK,
		S_F_NB,
		S_F_CHK,
		S_F_T,
		S_F_N,
		S_F_WR,
		S_LNK,
		S_DONE
	} state_t;

endpackage

// ===== sv/boundary_tag_first_fit_allocator.sv =====
// channel   | signals            | handshake
// ----------+--------------------+-------------------------------------------
// command   | start, cmd         | word taken when start is high, busy low
// result    | done, result       | word shown for one cycle while done high
//
// After reset a clearing pass writes all 4096 heap words, one per cycle, with
// busy held high. An allocate takes longer for each free-list node passed
// over, and a free takes longer for each node walked.
// The single heap memory port (one read, one write a cycle) paces both walks.
// The receiver cannot stall: done is high for one cycle, then busy drops.
module boundary_tag_first_fit_allocator (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  btff_pkg::cmd_t   cmd,
	output logic             done,
	output btff_pkg::res_t   result
);

	localparam int AW = btff_pkg::ADDR_W;
	localparam int XW = btff_pkg::EXT_W;
	localparam int WW = btff_pkg::WORD_W;
	localparam int NW = btff_pkg::NEED_W;
	localparam int SW = btff_pkg::STEP_W;

	// heap memory
	logic [WW-1:0] mem [btff_pkg::HEAP_WORDS];
	logic [WW-1:0] rdata_q;
	logic          roor_q;

	btff_pkg::state_t state_q, state_d;

	logic [AW-1:0] clr_q;
	logic [NW-1:0] need_q;
	logic [WW-1:0] cur_q, prev_q, succ_q, nxt_q, link_q, head_q, t_q;
	logic [SW-1:0] steps_q;
	logic [AW-1:0] hdr_q, ms_q;
	logic [SW-1:0] msz_q;
	logic          last_q;
	logic [2:0]    wstep_q;
	btff_pkg::res_t res_q;

	logic [XW-1:0] raddr, waddr;
	logic          we;
	logic [WW-1:0] wdata;

	// read data, zero outside the heap
	logic [WW-1:0] rd_w;
	logic [AW-1:0] rd_sz, t_sz;
	assign rd_w  = roor_q ? '0 : rdata_q;
	assign rd_sz = rd_w[AW-1:0];
	assign t_sz  = t_q[AW-1:0];

	// alloc helpers
	logic [NW-1:0] need_in;
	logic [NW-1:0] need_raw;
	logic          a_fit, a_split, a_term;
	logic [XW-1:0] cur_x;
	assign need_raw = NW'(({1'b0, cmd.request_bytes} + 16'(btff_pkg::BYTES_PER_WORD - 1))
		>> btff_pkg::BPW_SHIFT) + NW'(2);
	assign need_in  = (need_raw < NW'(btff_pkg::MIN_BLOCK)) ?
		NW'(btff_pkg::MIN_BLOCK) : need_raw;
	assign cur_x    = XW'(cur_q);
	assign a_fit    = NW'(rd_sz) >= need_q;
	assign a_split  = NW'(t_sz) > (need_q + NW'(btff_pkg::SPLIT_SLACK));
	assign a_term   = (cur_q == '0) || (cur_q[WW-1:AW] != '0) || steps_q[SW-1];

	// free helpers
	logic [SW-1:0] nh_w, end_w;
	logic          f_hdr_ok, f_prv_ok, f_nb_ok;
	assign f_hdr_ok = rd_w[btff_pkg::ALLOC_POS] && (rd_sz >= AW'(btff_pkg::MIN_BLOCK))
		&& (SW'(rd_sz) <= (SW'(btff_pkg::HEAP_WORDS) - SW'(hdr_q)));
	assign f_prv_ok = !rd_w[btff_pkg::ALLOC_POS] && (rd_sz >= AW'(btff_pkg::MIN_BLOCK))
		&& (rd_sz <= (hdr_q - AW'(1)));
	assign nh_w     = SW'(hdr_q) + SW'(t_sz);
	assign f_nb_ok  = !nh_w[SW-1] && !rd_w[btff_pkg::ALLOC_POS]
		&& (rd_sz >= AW'(btff_pkg::MIN_BLOCK))
		&& (SW'(rd_sz) <= (SW'(btff_pkg::HEAP_WORDS) - nh_w));
	assign end_w    = SW'(ms_q) + msz_q;

	logic          w_last;
	logic [WW-1:0] link_d;
	assign w_last = (state_q == btff_pkg::S_F_WR) ? (wstep_q == 3'd2) :
		(a_split ? (wstep_q == 3'd4) : (wstep_q == 3'd1));
	assign link_d = (state_q == btff_pkg::S_F_WR) ? WW'(ms_q) :
		(a_split ? WW'(cur_x + XW'(need_q)) : nxt_q);

	// memory: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (we && (waddr[XW-1:AW] == '0))
			mem[waddr[AW-1:0]] <= wdata;
		rdata_q <= mem[raddr[AW-1:0]];
		roor_q  <= raddr[XW-1:AW] != '0;
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= btff_pkg::S_CLEAR;
		else
			state_q <= state_d;
	end

	// next state, memory control and handshake
	always_comb begin
		state_d = state_q;
		raddr   = '0;
		waddr   = '0;
		wdata   = '0;
		we      = 1'b0;
		busy    = 1'b1;
		done    = 1'b0;
		result  = res_q;
		unique case (state_q)
			btff_pkg::S_CLEAR: begin
				we    = 1'b1;
				waddr = XW'(clr_q);
				if (clr_q == AW'(1) || clr_q == AW'(btff_pkg::HEAP_WORDS - 1))
					wdata = {1'b0, 1'b1, AW'(btff_pkg::HEAP_WORDS - 1)};
				if (clr_q == AW'(btff_pkg::HEAP_WORDS - 1))
					state_d = btff_pkg::S_IDLE;
			end
			btff_pkg::S_IDLE: begin
				busy = 1'b0;
				if (start) begin
					if (cmd.mode == btff_pkg::MODE_ALLOC)
						state_d = btff_pkg::S_A_CHK;
					else if (cmd.block_offset == '0)
						state_d = btff_pkg::S_DONE;
					else begin
						raddr   = XW'(cmd.block_offset - AW'(1));
						state_d = btff_pkg::S_F_HDR;
					end
				end
			end
			btff_pkg::S_A_CHK: begin
				raddr = cur_x;
				state_d = a_term ? btff_pkg::S_DONE : btff_pkg::S_A_TAG;
			end
			btff_pkg::S_A_TAG: begin
				raddr   = cur_x + XW'(rd_sz) - XW'(2);
				state_d = a_fit ? btff_pkg::S_A_NXT : btff_pkg::S_A_ADV;
			end
			btff_pkg::S_A_ADV: state_d = btff_pkg::S_A_CHK;
			btff_pkg::S_A_NXT: state_d = btff_pkg::S_A_WR;
			btff_pkg::S_A_WR: begin
				we = 1'b1;
				if (a_split) begin
					unique case (wstep_q)
						3'd0: begin
							waddr = cur_x;
							wdata = {1'b1, 1'b0, need_q[AW-1:0]};
						end
						3'd1: begin
							waddr = cur_x + XW'(need_q) - XW'(1);
							wdata = {1'b1, 1'b0, need_q[AW-1:0]};
						end
						3'd2: begin
							waddr = cur_x + XW'(need_q);
							wdata = {1'b0, t_q[btff_pkg::LAST_POS], t_sz - need_q[AW-1:0]};
						end
						3'd3: begin
							waddr = cur_x + XW'(t_sz) - XW'(1);
							wdata = {1'b0, t_q[btff_pkg::LAST_POS], t_sz - need_q[AW-1:0]};
						end
						default: begin
							waddr = cur_x + XW'(t_sz) - XW'(2);
							wdata = nxt_q;
						end
					endcase
				end else begin
					waddr = (wstep_q == 3'd0) ? cur_x : cur_x + XW'(t_sz) - XW'(1);
					wdata = {1'b1, t_q[btff_pkg::LAST_POS], t_sz};
				end
				if (w_last) begin
					raddr   = XW'(prev_q);
					state_d = (prev_q == '0) ? btff_pkg::S_DONE : btff_pkg::S_LNK;
				end
			end
			btff_pkg::S_F_HDR: begin
				raddr   = XW'(hdr_q) + XW'(rd_sz) - XW'(1);
				state_d = f_hdr_ok ? btff_pkg::S_F_FTR : btff_pkg::S_DONE;
			end
			btff_pkg::S_F_FTR: begin
				raddr = XW'(hdr_q) - XW'(1);
				if (rd_w != t_q)
					state_d = btff_pkg::S_DONE;
				else if (hdr_q > AW'(1))
					state_d = btff_pkg::S_F_PRV;
				else
					state_d = btff_pkg::S_F_NXTCHK;
			end
			btff_pkg::S_F_PRV: state_d = btff_pkg::S_F_NXTCHK;
			btff_pkg::S_F_NXTCHK: begin
				raddr   = XW'(nh_w);
				state_d = last_q ? btff_pkg::S_F_CHK : btff_pkg::S_F_NB;
			end
			btff_pkg::S_F_NB: state_d = btff_pkg::S_F_CHK;
			btff_pkg::S_F_CHK: begin
				raddr = cur_x;
				if (a_term)
					state_d = btff_pkg::S_F_WR;
				else if (cur_q >= WW'(ms_q) && cur_q >= WW'(end_w))
					state_d = btff_pkg::S_F_WR;
				else
					state_d = btff_pkg::S_F_T;
			end
			btff_pkg::S_F_T: begin
				raddr   = cur_x + XW'(rd_sz) - XW'(2);
				state_d = btff_pkg::S_F_N;
			end
			btff_pkg::S_F_N: state_d = btff_pkg::S_F_CHK;
			btff_pkg::S_F_WR: begin
				we = 1'b1;
				unique case (wstep_q)
					3'd0: begin
						waddr = XW'(ms_q);
						wdata = {1'b0, last_q, msz_q[AW-1:0]};
					end
					3'd1: begin
						waddr = XW'(ms_q) + XW'(msz_q) - XW'(1);
						wdata = {1'b0, last_q, msz_q[AW-1:0]};
					end
					default: begin
						waddr = XW'(ms_q) + XW'(msz_q) - XW'(2);
						wdata = succ_q;
					end
				endcase
				if (w_last) begin
					raddr   = XW'(prev_q);
					state_d = (prev_q == '0) ? btff_pkg::S_DONE : btff_pkg::S_LNK;
				end
			end
			btff_pkg::S_LNK: begin
				we      = 1'b1;
				waddr   = XW'(prev_q) + XW'(rd_sz) - XW'(2);
				wdata   = link_q;
				state_d = btff_pkg::S_DONE;
			end
			btff_pkg::S_DONE: begin
				done    = 1'b1;
				state_d = btff_pkg::S_IDLE;
			end
			default: state_d = btff_pkg::S_IDLE;
		endcase
	end

	// control registers: clear counter, list head
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q  <= '0;
			head_q <= WW'(1);
		end else begin
			if (state_q == btff_pkg::S_CLEAR)
				clr_q <= clr_q + AW'(1);
			if ((state_q == btff_pkg::S_A_WR || state_q == btff_pkg::S_F_WR)
				&& w_last && prev_q == '0)
				head_q <= link_d;
		end
	end

	// sequencer datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			btff_pkg::S_IDLE: begin
				res_q   <= '{status: btff_pkg::ST_DONE, payload_offset: '0};
				need_q  <= need_in;
				cur_q   <= head_q;
				prev_q  <= '0;
				steps_q <= '0;
				hdr_q   <= cmd.block_offset - AW'(1);
				wstep_q <= '0;
			end
			btff_pkg::S_A_CHK: begin
				if (a_term)
					res_q.status <= btff_pkg::ST_NOFIT;
			end
			btff_pkg::S_A_TAG: t_q <= rd_w;
			btff_pkg::S_A_ADV: begin
				prev_q  <= cur_q;
				cur_q   <= rd_w;
				steps_q <= steps_q + SW'(1);
			end
			btff_pkg::S_A_NXT: nxt_q <= rd_w;
			btff_pkg::S_A_WR: begin
				wstep_q <= wstep_q + 3'd1;
				if (w_last) begin
					link_q               <= link_d;
					res_q.payload_offset <= cur_q[AW-1:0] + AW'(1);
				end
			end
			btff_pkg::S_F_HDR: t_q <= rd_w;
			btff_pkg::S_F_FTR: begin
				ms_q   <= hdr_q;
				msz_q  <= SW'(t_sz);
				last_q <= t_q[btff_pkg::LAST_POS];
			end
			btff_pkg::S_F_PRV: begin
				if (f_prv_ok) begin
					ms_q  <= hdr_q - rd_sz;
					msz_q <= msz_q + SW'(rd_sz);
				end
			end
			btff_pkg::S_F_NXTCHK: begin
				cur_q   <= head_q;
				steps_q <= '0;
				succ_q  <= '0;
			end
			btff_pkg::S_F_NB: begin
				if (f_nb_ok) begin
					msz_q  <= msz_q + SW'(rd_sz);
					last_q <= rd_w[btff_pkg::LAST_POS];
				end
			end
			btff_pkg::S_F_CHK: begin
				if (!a_term) begin
					if (cur_q < WW'(ms_q))
						prev_q <= cur_q;
					else if (cur_q >= WW'(end_w))
						succ_q <= cur_q;
				end
			end
			btff_pkg::S_F_N: begin
				cur_q   <= rd_w;
				steps_q <= steps_q + SW'(1);
			end
			btff_pkg::S_F_WR: begin
				wstep_q <= wstep_q + 3'd1;
				if (w_last)
					link_q <= link_d;
			end
			default: ;
		endcase
	end

endmodule

// ===== sv/btff_checker.sv =====
module btff_props (
	input logic           clk,
	input logic           arst_n,
	input logic           start,
	input logic           busy,
	input btff_pkg::cmd_t cmd,
	input logic           done,
	input btff_pkg::res_t result
);

	// an accepted word makes the block busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted word did not raise busy");

	// a result only appears while busy
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("result strobe while idle");

	// one result per word, then ready again
	a_done_once: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> (!done && !busy))
		else $error("result strobe not followed by idle");

	// a failed allocate reports a zero offset
	a_nofit_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status == btff_pkg::ST_NOFIT) |-> (result.payload_offset == '0))
		else $error("no-fit result with nonzero offset");

endmodule

bind boundary_tag_first_fit_allocator btff_props u_btff_props (.*);
